// ===== hw/rtl/mtwm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and byte helpers for the word match scorer
package mtwm_pkg;

  typedef enum logic [1:0] {
    OP_TEXT   = 2'd0,
    OP_NEWDOC = 2'd1,
    OP_FINISH = 2'd2,
    OP_LOAD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_TERM_COUNT   = 2'd0,
    REG_PREFIX_MASK  = 2'd1,
    REG_TERM_LENGTHS = 2'd2,
    REG_NONE         = 2'd3
  } reg_e;

  localparam int unsigned ScoreW = 25;
  localparam int unsigned CfgW   = 48;
  localparam int unsigned LenW   = 6;
  localparam int unsigned LenRegs = 8;

  typedef struct packed {
    logic       rd;
    logic       start;
    logic       cmp;
    logic       chk;
    logic       upd;
    logic       clr;
    logic [7:0] data;
  } cell_ctl_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    logic r;
    r = (c >= 8'h80) || (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
        (c >= "a" && c <= "z") || (c == "_");
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    return r;
  endfunction

endpackage

// ===== hw/rtl/mtwm_cell.sv =====
`timescale 1ns / 1ps
// one term cell: pattern bytes, match tracking and run credit
module mtwm_cell import mtwm_pkg::*; #(
  parameter int unsigned IDX             = 0,
  parameter int unsigned MAX_TERMS       = 8,
  parameter int unsigned MAX_TERM_LEN    = 32,
  parameter int unsigned WORD_INDEX_BITS = 32,
  localparam int unsigned TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned CW  = $clog2(MAX_TERMS + 1),
  localparam int unsigned PW  = $clog2(MAX_TERM_LEN + 2),
  localparam int unsigned AW  = $clog2(MAX_TERM_LEN)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctl_t                  ctl_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [AW-1:0]              raddr_i,
  input  logic [LenW-1:0]            len_i,
  input  logic                       prefix_i,
  input  logic                       en_i,
  input  logic [PW-1:0]              pos_i,
  input  logic [WORD_INDEX_BITS-1:0] wc_i,
  input  logic [TIW-1:0]             win_idx_i,
  input  logic                       win_i,
  input  logic [CW-1:0]              k_i,
  input  logic                       run_i,
  output logic                       run_o,
  output logic                       hit_o,
  output logic [CW-1:0]              credit_o
);

  localparam logic [TIW-1:0] IdxV = TIW'(IDX);

  logic [7:0]                 mem [MAX_TERM_LEN];
  logic [7:0]                 rdata_q;
  logic                       alive_q;
  logic [CW-1:0]              credit_q;
  logic [WORD_INDEX_BITS-1:0] lmw_q;
  logic                       ok_q;
  logic                       ok_d;
  logic [WORD_INDEX_BITS-1:0] span;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= ctl_i.data;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign span = WORD_INDEX_BITS'(win_idx_i) - WORD_INDEX_BITS'(IdxV);
  assign ok_d = (IdxV < win_idx_i) && (credit_q != '0) && (lmw_q == wc_i - span);

  assign hit_o = en_i && alive_q &&
                 (prefix_i ? (8'(pos_i) >= 8'(len_i)) : (8'(pos_i) == 8'(len_i)));
  assign run_o    = win_i || (run_i && ok_q);
  assign credit_o = credit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q  <= 1'b0;
      credit_q <= '0;
      lmw_q    <= '1;
      ok_q     <= 1'b0;
    end else if (ctl_i.clr) begin
      alive_q  <= 1'b0;
      credit_q <= '0;
      lmw_q    <= '1;
      ok_q     <= 1'b0;
    end else begin
      if (ctl_i.start) begin
        alive_q <= 1'b1;
      end
      if (ctl_i.cmp && 8'(pos_i) < 8'(len_i) && 8'(pos_i) < 8'(MAX_TERM_LEN) &&
          fold(rdata_q) != fold(ctl_i.data)) begin
        alive_q <= 1'b0;
      end
      if (ctl_i.chk) begin
        ok_q <= ok_d;
      end
      if (ctl_i.upd) begin
        if (run_o && credit_q < k_i) begin
          credit_q <= k_i;
        end
        if (win_i) begin
          lmw_q <= wc_i;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/multi_term_word_match_scorer.sv =====
`timescale 1ns / 1ps
// top level of the multi-term word match scorer with its sequencer
// usage:
//   input channel: in_valid_i / in_stall_o carry one item per transfer
//   (operation, text byte, term index, char position)
//   output channel: out_valid_o / out_stall_i carry score and terms seen,
//   one transfer per finish item and none for other items
//   config port: cfg_we_i writes cfg_data_i to register cfg_index_i at once;
//   the user must write only while the block is idle; the block does not enforce it
// sequence:
//   load item: written in idle; word byte: pattern read, then compare
//   separator byte or new document: pick winner, check run
//   neighbours, update credits along the cell row
//   finish: those steps, then the credit product, then the result register
//   one item is worked on at a time; the next is taken on return to idle
// reset: config registers zero, credits cleared, word count zero; the
//   pattern memory is not cleared and holds garbage until loaded
// a stalled result stays in its register; a new finish waits for it to go
module multi_term_word_match_scorer import mtwm_pkg::*; #(
  parameter int unsigned MAX_TERMS       = 8,
  parameter int unsigned MAX_TERM_LEN    = 32,
  parameter int unsigned WORD_INDEX_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        text_byte_i,
  input  logic [2:0]        term_index_i,
  input  logic [4:0]        char_position_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ScoreW-1:0] score_o,
  output logic [7:0]        terms_seen_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  localparam int unsigned TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW  = $clog2(MAX_TERMS + 1);
  localparam int unsigned PW  = $clog2(MAX_TERM_LEN + 2);
  localparam int unsigned AW  = $clog2(MAX_TERM_LEN);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMP  = 7'b0000010,
    S_END1 = 7'b0000100,
    S_END2 = 7'b0001000,
    S_END3 = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]                 tc_q;
  logic [7:0]                 pmask_q;
  logic [CfgW-1:0]            lens_q;
  logic [1:0]                 op_q;
  logic [7:0]                 byte_q;
  logic                       inside_q;
  logic [PW-1:0]              pos_q;
  logic [WORD_INDEX_BITS-1:0] wc_q;
  logic [MAX_TERMS-1:0]       win_q;
  logic [TIW-1:0]             win_idx_q;
  logic [CW-1:0]              idx_q;
  logic [ScoreW-1:0]          score_q;
  logic [7:0]                 seen_q;
  logic                       out_valid_q;
  logic [ScoreW-1:0]          out_score_q;
  logic [7:0]                 out_seen_q;

  logic                       accept;
  logic                       word_byte;
  logic [CW-1:0]              tc_eff;
  logic [MAX_TERMS-1:0]       hit;
  logic [MAX_TERMS-1:0]       win_d;
  logic [TIW-1:0]             win_idx_d;
  logic [MAX_TERMS:0]         run;
  logic [CW-1:0]              k;
  logic [CW-1:0]              credit [MAX_TERMS];
  logic                       out_free;
  cell_ctl_t                  ctl;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign word_byte = is_word_byte(text_byte_i);
  assign tc_eff    = (32'(tc_q) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(tc_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign score_o      = out_score_q;
  assign terms_seen_o = out_seen_q;

  // control to the cell row
  always_comb begin
    ctl.rd    = accept && (operation_i == OP_TEXT) && word_byte;
    ctl.start = ctl.rd && !inside_q;
    ctl.cmp   = (state_q == S_CMP);
    ctl.chk   = (state_q == S_END2);
    ctl.upd   = (state_q == S_END3);
    ctl.clr   = (state_q == S_OUT) && out_free;
    ctl.data  = (state_q == S_IDLE) ? text_byte_i : byte_q;
  end

  // lowest hitting term wins
  always_comb begin
    win_d     = '0;
    win_idx_d = '0;
    for (int i = MAX_TERMS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        win_d     = '0;
        win_d[i]  = 1'b1;
        win_idx_d = TIW'(i);
      end
    end
  end

  assign run[MAX_TERMS] = 1'b0;
  assign k = CW'($countones(run[MAX_TERMS-1:0]));

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic [LenW-1:0] len;
    logic            pfx;
    logic            en;
    logic            we;
    if (i < LenRegs) begin : g_cfg
      assign len = lens_q[LenW*i +: LenW];
      assign pfx = pmask_q[i];
    end else begin : g_nocfg
      assign len = '0;
      assign pfx = 1'b0;
    end
    assign en = inside_q && (CW'(i) < tc_eff) && (32'(len) <= MAX_TERM_LEN);
    assign we = accept && (operation_i == OP_LOAD) && (32'(term_index_i) == i) &&
                (32'(char_position_i) < MAX_TERM_LEN);

    mtwm_cell #(
      .IDX            (i),
      .MAX_TERMS      (MAX_TERMS),
      .MAX_TERM_LEN   (MAX_TERM_LEN),
      .WORD_INDEX_BITS(WORD_INDEX_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .we_i     (we),
      .waddr_i  (AW'(char_position_i)),
      .raddr_i  (inside_q ? AW'(pos_q) : '0),
      .len_i    (len),
      .prefix_i (pfx),
      .en_i     (en),
      .pos_i    (pos_q),
      .wc_i     (wc_q),
      .win_idx_i(win_idx_q),
      .win_i    (win_q[i]),
      .k_i      (k),
      .run_i    (run[i+1]),
      .run_o    (run[i]),
      .hit_o    (hit[i]),
      .credit_o (credit[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_LOAD) begin
            state_d = S_IDLE;
          end else if (operation_i == OP_TEXT && word_byte) begin
            state_d = S_CMP;
          end else begin
            state_d = S_END1;
          end
        end
      end
      S_CMP:  state_d = S_IDLE;
      S_END1: state_d = S_END2;
      S_END2: state_d = S_END3;
      S_END3: state_d = (op_q == OP_FINISH) ? S_MUL : S_IDLE;
      S_MUL:  state_d = (idx_q == tc_eff) ? S_OUT : S_MUL;
      S_OUT:  state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tc_q        <= '0;
      pmask_q     <= '0;
      lens_q      <= '0;
      op_q        <= OP_TEXT;
      byte_q      <= '0;
      inside_q    <= 1'b0;
      pos_q       <= '0;
      wc_q        <= '0;
      win_q       <= '0;
      win_idx_q   <= '0;
      idx_q       <= '0;
      score_q     <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      out_score_q <= '0;
      out_seen_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TERM_COUNT:   tc_q    <= cfg_data_i[3:0];
          REG_PREFIX_MASK:  pmask_q <= cfg_data_i[7:0];
          REG_TERM_LENGTHS: lens_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= operation_i;
            byte_q <= text_byte_i;
            if (ctl.start) begin
              inside_q <= 1'b1;
              wc_q     <= wc_q + 1'b1;
              pos_q    <= '0;
            end
          end
        end
        S_CMP: begin
          if (32'(pos_q) <= MAX_TERM_LEN) begin
            pos_q <= pos_q + 1'b1;
          end
        end
        S_END1: begin
          win_q     <= inside_q ? win_d : '0;
          win_idx_q <= win_idx_d;
          inside_q  <= 1'b0;
        end
        S_END2: ;
        S_END3: begin
          win_q   <= '0;
          idx_q   <= '0;
          score_q <= ScoreW'(1);
          seen_q  <= '0;
          if (op_q == OP_NEWDOC) begin
            wc_q <= wc_q + 1'b1;
          end
        end
        S_MUL: begin
          if (idx_q != tc_eff) begin
            score_q <= ScoreW'(score_q * credit[TIW'(idx_q)]);
            if (32'(idx_q) < LenRegs && credit[TIW'(idx_q)] != '0) begin
              seen_q[3'(idx_q)] <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_score_q <= score_q;
            out_seen_q  <= seen_q;
            wc_q        <= '0;
            pos_q       <= '0;
            inside_q    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
